// ----- rtl/spf_pkg.sv -----
package spf_pkg;

  // Queue geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int ACTION_W  = 3;
  localparam int TAG_W     = 32;
  localparam int SIZE_W    = 24;
  localparam int DUR_W     = 32;
  localparam int SERIAL_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int ECOUNT_W  = 7;
  localparam int BYTES_W   = 40;
  localparam int TDUR_W    = 48;
  localparam int OVH_W     = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 3'd0,
    ACT_GET   = 3'd1,
    ACT_FLUSH = 3'd2,
    ACT_START = 3'd3,
    ACT_ABORT = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ABORTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One stored queue entry
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    dur;
    logic [SERIAL_W-1:0] serial;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Entry store access for one word
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wentry;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Word in flight between the control stage and the totals stage
  typedef struct packed {
    status_t            status;
    logic               put_ok;
    logic               get_ok;
    logic               flush;
    logic [CNT_W-1:0]   count;
    logic [SIZE_W-1:0]  size;
    logic [DUR_W-1:0]   dur;
  } stage_t;

endpackage

// ----- rtl/spf_ram.sv -----
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/spf_ctrl.sv -----
module spf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spf_pkg::ACTION_W-1:0]   in_action,
  input  logic [spf_pkg::TAG_W-1:0]      in_pkt_tag,
  input  logic [spf_pkg::SIZE_W-1:0]     in_pkt_size,
  input  logic [spf_pkg::DUR_W-1:0]      in_pkt_duration,
  input  logic                           b_take,
  output logic                           b_valid_r,
  output spf_pkg::stage_t                b_r,
  output spf_pkg::ram_req_t              ram_req
);
  import spf_pkg::*;

  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic                aborted_r, aborted_nxt;
  logic                b_valid_nxt;
  logic                accept;
  stage_t              stg;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  // Stage slot frees when its word moves on
  assign in_ready = !b_valid_r || b_take;
  assign accept   = in_valid && in_ready;

  // Action decode against queue state
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    serial_nxt  = serial_r;
    aborted_nxt = aborted_r;
    stg         = '0;
    stg.status  = ST_OK;
    stg.size    = in_pkt_size;
    stg.dur     = in_pkt_duration;
    case (action_t'(in_action))
      ACT_PUT: begin
        if (aborted_r) begin
          stg.status = ST_ABORTED;
        end else if (count_r >= FULL_CNT) begin
          stg.status = ST_FULL;
        end else begin
          stg.put_ok = 1'b1;
          tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end
      ACT_GET: begin
        if (aborted_r) begin
          stg.status = ST_ABORTED;
        end else if (count_r == '0) begin
          stg.status = ST_EMPTY;
        end else begin
          stg.get_ok = 1'b1;
          head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      ACT_FLUSH: begin
        stg.flush  = 1'b1;
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
        serial_nxt = serial_r + 1'b1;
      end
      ACT_START: begin
        aborted_nxt = 1'b0;
        serial_nxt  = serial_r + 1'b1;
      end
      ACT_ABORT: begin
        aborted_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    stg.count = count_nxt;
  end

  // Entry store: write at tail on put, read head on get
  always_comb begin
    ram_req               = '0;
    ram_req.we            = accept && stg.put_ok;
    ram_req.waddr         = tail_r;
    ram_req.wentry.tag    = in_pkt_tag;
    ram_req.wentry.size   = in_pkt_size;
    ram_req.wentry.dur    = in_pkt_duration;
    ram_req.wentry.serial = serial_r;
    ram_req.re            = accept && stg.get_ok;
    ram_req.raddr         = head_r;
  end

  assign b_valid_nxt = accept ? 1'b1 : (b_take ? 1'b0 : b_valid_r);

  // Queue state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      serial_r  <= '0;
      aborted_r <= 1'b1;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        count_r   <= count_nxt;
        serial_r  <= serial_nxt;
        aborted_r <= aborted_nxt;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_r <= stg;
    end
  end

endmodule

// ----- rtl/spf_acc.sv -----
module spf_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [spf_pkg::OVH_W-1:0]      cfg_wr_data,
  input  logic                           b_valid,
  input  spf_pkg::stage_t                b,
  input  spf_pkg::entry_t                rd_entry,
  output logic                           b_take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spf_pkg::STATUS_W-1:0]   out_status,
  output logic [spf_pkg::TAG_W-1:0]      out_tag,
  output logic [spf_pkg::SIZE_W-1:0]     out_size,
  output logic [spf_pkg::DUR_W-1:0]      out_duration,
  output logic [spf_pkg::SERIAL_W-1:0]   out_serial,
  output logic [spf_pkg::ECOUNT_W-1:0]   out_entry_count,
  output logic [spf_pkg::BYTES_W-1:0]    out_total_bytes,
  output logic [spf_pkg::TDUR_W-1:0]     out_total_duration
);
  import spf_pkg::*;

  logic [OVH_W-1:0]   ovh_r;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [TDUR_W-1:0]  tdur_r, tdur_nxt;
  logic               out_valid_r, out_valid_nxt;
  entry_t             oent_r, oent_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [ECOUNT_W-1:0] ecount_r;
  logic               load;

  assign b_take = !out_valid_r || out_ready;
  assign load   = b_valid && b_take;

  // Running totals
  always_comb begin
    bytes_nxt = bytes_r;
    tdur_nxt  = tdur_r;
    oent_nxt  = '0;
    if (b.flush) begin
      bytes_nxt = '0;
      tdur_nxt  = '0;
    end else if (b.put_ok) begin
      bytes_nxt = bytes_r + BYTES_W'(b.size) + BYTES_W'(ovh_r);
      tdur_nxt  = tdur_r + TDUR_W'(b.dur);
    end else if (b.get_ok) begin
      oent_nxt  = rd_entry;
      bytes_nxt = bytes_r - BYTES_W'(rd_entry.size) - BYTES_W'(ovh_r);
      tdur_nxt  = tdur_r - TDUR_W'(rd_entry.dur);
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control state, overhead register and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovh_r       <= '0;
      bytes_r     <= '0;
      tdur_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ovh_r <= cfg_wr_data;
      end
      if (load) begin
        bytes_r <= bytes_nxt;
        tdur_r  <= tdur_nxt;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (load) begin
      oent_r   <= oent_nxt;
      status_r <= b.status;
      ecount_r <= ECOUNT_W'(b.count);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_tag            = oent_r.tag;
  assign out_size           = oent_r.size;
  assign out_duration       = oent_r.dur;
  assign out_serial         = oent_r.serial;
  assign out_entry_count    = ecount_r;
  assign out_total_bytes    = bytes_r;
  assign out_total_duration = tdur_r;

endmodule

// ----- rtl/serial_packet_fifo.sv -----
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------
// input    | in_action, in_pkt_tag/size/duration     | in_valid/in_ready
// result   | out_status ... out_total_duration       | out_valid/out_ready
// config   | cfg_wr_data (entry overhead)            | cfg_wr_en
//
// One word per cycle sustained while out_ready keeps the result side moving; the
// accepting edge registers the queue control and the entry store read, and once
// the result register is free the running totals are loaded into it with the result.
// Reset (rst_n low, synchronous) empties the queue and leaves it aborted.
// A stalled result holds the totals stage; one more word may be taken then.
module serial_packet_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [spf_pkg::OVH_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spf_pkg::ACTION_W-1:0]   in_action,
  input  logic [spf_pkg::TAG_W-1:0]      in_pkt_tag,
  input  logic [spf_pkg::SIZE_W-1:0]     in_pkt_size,
  input  logic [spf_pkg::DUR_W-1:0]      in_pkt_duration,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spf_pkg::STATUS_W-1:0]   out_status,
  output logic [spf_pkg::TAG_W-1:0]      out_tag,
  output logic [spf_pkg::SIZE_W-1:0]     out_size,
  output logic [spf_pkg::DUR_W-1:0]      out_duration,
  output logic [spf_pkg::SERIAL_W-1:0]   out_serial,
  output logic [spf_pkg::ECOUNT_W-1:0]   out_entry_count,
  output logic [spf_pkg::BYTES_W-1:0]    out_total_bytes,
  output logic [spf_pkg::TDUR_W-1:0]     out_total_duration
);
  import spf_pkg::*;

  logic             b_take;
  logic             b_valid;
  stage_t           b_stage;
  ram_req_t         ram_req;
  logic [ENTRY_W-1:0] rd_data;

  // Queue control and entry store addressing
  spf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_pkt_tag      (in_pkt_tag),
    .in_pkt_size     (in_pkt_size),
    .in_pkt_duration (in_pkt_duration),
    .b_take          (b_take),
    .b_valid_r       (b_valid),
    .b_r             (b_stage),
    .ram_req         (ram_req)
  );

  // Entry store
  spf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wentry),
    .re      (ram_req.re),
    .raddr   (ram_req.raddr),
    .rdata_r (rd_data)
  );

  // Totals and result register
  spf_acc u_acc (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .b_valid            (b_valid),
    .b                  (b_stage),
    .rd_entry           (entry_t'(rd_data)),
    .b_take             (b_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_tag            (out_tag),
    .out_size           (out_size),
    .out_duration       (out_duration),
    .out_serial         (out_serial),
    .out_entry_count    (out_entry_count),
    .out_total_bytes    (out_total_bytes),
    .out_total_duration (out_total_duration)
  );

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  // Spare action codes: the block ignores them
  localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;

  localparam int RAND_PHASES = 6;
  localparam int PHASE_WORDS = 285;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TAG_W-1:0]    tag;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    dur;
  } fifo_word_t;

  typedef struct packed {
    status_t             status;
    logic [TAG_W-1:0]    tag;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    dur;
    logic [SERIAL_W-1:0] serial;
    logic [ECOUNT_W-1:0] count;
    logic [BYTES_W-1:0]  bytes;
    logic [TDUR_W-1:0]   tdur;
  } fifo_result_t;

  typedef struct {
    fifo_word_t   word;
    bit           typed;
    fifo_result_t want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [OVH_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = '0;
  logic [TAG_W-1:0]    in_pkt_tag = '0;
  logic [SIZE_W-1:0]   in_pkt_size = '0;
  logic [DUR_W-1:0]    in_pkt_duration = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_tag;
  logic [SIZE_W-1:0]   out_size;
  logic [DUR_W-1:0]    out_duration;
  logic [SERIAL_W-1:0] out_serial;
  logic [ECOUNT_W-1:0] out_entry_count;
  logic [BYTES_W-1:0]  out_total_bytes;
  logic [TDUR_W-1:0]   out_total_duration;

  serial_packet_fifo dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_pkt_tag         (in_pkt_tag),
    .in_pkt_size        (in_pkt_size),
    .in_pkt_duration    (in_pkt_duration),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_tag            (out_tag),
    .out_size           (out_size),
    .out_duration       (out_duration),
    .out_serial         (out_serial),
    .out_entry_count    (out_entry_count),
    .out_total_bytes    (out_total_bytes),
    .out_total_duration (out_total_duration)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue, its totals and the overhead register
  entry_t              shadow_store [DEPTH];
  logic [ADDR_W-1:0]   shadow_head = '0;
  logic [ADDR_W-1:0]   shadow_tail = '0;
  int                  shadow_count = 0;
  logic [BYTES_W-1:0]  shadow_bytes = '0;
  logic [TDUR_W-1:0]   shadow_tdur = '0;
  logic [SERIAL_W-1:0] shadow_serial = '0;
  bit                  shadow_aborted = 1'b1;
  logic [OVH_W-1:0]    shadow_overhead = '0;

  fifo_result_t  pending_results [$];
  directed_row_t directed_rows [$];
  int            mismatches = 0;
  bit            steady = 1'b0;

  function automatic logic [ADDR_W-1:0] wrap_next(logic [ADDR_W-1:0] i);
    return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Apply one word to the shadow queue and return the result it yields
  function automatic fifo_result_t apply_action(fifo_word_t w);
    fifo_result_t r;
    entry_t       e;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_PUT: begin
        if (shadow_aborted) begin
          r.status = ST_ABORTED;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.tag = w.tag;
          e.size = w.size;
          e.dur = w.dur;
          e.serial = shadow_serial;
          shadow_store[shadow_tail] = e;
          shadow_tail = wrap_next(shadow_tail);
          shadow_count++;
          shadow_bytes = shadow_bytes + BYTES_W'(w.size) + BYTES_W'(shadow_overhead);
          shadow_tdur = shadow_tdur + TDUR_W'(w.dur);
        end
      end
      ACT_GET: begin
        if (shadow_aborted) begin
          r.status = ST_ABORTED;
        end else if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = shadow_store[shadow_head];
          r.tag = e.tag;
          r.size = e.size;
          r.dur = e.dur;
          r.serial = e.serial;
          shadow_head = wrap_next(shadow_head);
          shadow_count--;
          // current overhead is taken off, so the byte total may drift
          shadow_bytes = shadow_bytes - BYTES_W'(e.size) - BYTES_W'(shadow_overhead);
          shadow_tdur = shadow_tdur - TDUR_W'(e.dur);
        end
      end
      ACT_FLUSH: begin
        shadow_head = '0;
        shadow_tail = '0;
        shadow_count = 0;
        shadow_bytes = '0;
        shadow_tdur = '0;
        shadow_serial = shadow_serial + 1'b1;
      end
      ACT_START: begin
        shadow_aborted = 1'b0;
        shadow_serial = shadow_serial + 1'b1;
      end
      ACT_ABORT: shadow_aborted = 1'b1;
      default: ;
    endcase
    r.count = ECOUNT_W'(shadow_count);
    r.bytes = shadow_bytes;
    r.tdur = shadow_tdur;
    return r;
  endfunction

  function automatic fifo_result_t outcome(status_t st, logic [TAG_W-1:0] tag,
                                           logic [SIZE_W-1:0] size, logic [DUR_W-1:0] dur,
                                           logic [SERIAL_W-1:0] serial,
                                           logic [ECOUNT_W-1:0] count,
                                           logic [BYTES_W-1:0] bytes,
                                           logic [TDUR_W-1:0] tdur);
    fifo_result_t r;
    r.status = st;
    r.tag = tag;
    r.size = size;
    r.dur = dur;
    r.serial = serial;
    r.count = count;
    r.bytes = bytes;
    r.tdur = tdur;
    return r;
  endfunction

  function automatic void add_row(logic [ACTION_W-1:0] action, logic [TAG_W-1:0] tag,
                                  logic [SIZE_W-1:0] size, logic [DUR_W-1:0] dur,
                                  bit typed, fifo_result_t want);
    directed_row_t row;
    row.word.action = action;
    row.word.tag = tag;
    row.word.size = size;
    row.word.dur = dur;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Random word: mostly well-formed traffic, restart soon after an abort
  function automatic fifo_word_t pick_word(int put_bias);
    fifo_word_t w;
    int         r;
    r = $urandom_range(99);
    if (shadow_aborted && r < 70) begin
      w.action = ACT_START;
    end else begin
      r = $urandom_range(99);
      if (r < 1) w.action = ACT_ABORT;
      else if (r < 2) w.action = ACT_FLUSH;
      else if (r < 4) w.action = ACTION_W'(ACT_RSVD_A + $urandom_range(2));
      else if (r < 5) w.action = ACT_START;
      else if ($urandom_range(99) < put_bias) w.action = ACT_PUT;
      else w.action = ACT_GET;
    end
    w.tag = $urandom;
    case ($urandom_range(9))
      0: w.size = '0;
      1: w.size = '1;
      default: w.size = SIZE_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: w.dur = '0;
      1: w.dur = '1;
      default: w.dur = $urandom;
    endcase
    return w;
  endfunction

  // Present one word from a falling edge, hold it until taken
  task automatic send_word(fifo_word_t w, bit typed, fifo_result_t want);
    fifo_result_t predicted;
    if (!steady) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= w.action;
    in_pkt_tag <= w.tag;
    in_pkt_size <= w.size;
    in_pkt_duration <= w.dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_action(w);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Overhead is only changed with the pipeline drained
  task automatic write_overhead(logic [OVH_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    shadow_overhead = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [TDUR_W-1:0] want,
                                      logic [TDUR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // Compare every taken result with the oldest outstanding one
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result taken with no word outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_status", TDUR_W'(want.status), TDUR_W'(out_status));
        check_field("out_tag", TDUR_W'(want.tag), TDUR_W'(out_tag));
        check_field("out_size", TDUR_W'(want.size), TDUR_W'(out_size));
        check_field("out_duration", TDUR_W'(want.dur), TDUR_W'(out_duration));
        check_field("out_serial", TDUR_W'(want.serial), TDUR_W'(out_serial));
        check_field("out_entry_count", TDUR_W'(want.count), TDUR_W'(out_entry_count));
        check_field("out_total_bytes", TDUR_W'(want.bytes), TDUR_W'(out_total_bytes));
        check_field("out_total_duration", want.tdur, out_total_duration);
      end
    end
  end

  initial begin
    logic [OVH_W-1:0] ovh_plan [RAND_PHASES];
    int               put_bias;
    int               seg_left;
    fifo_word_t       w;

    // Directed table; typed rows follow from reset state and zero overhead
    add_row(ACT_GET, 0, 0, 0, 1, outcome(ST_ABORTED, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_PUT, 32'h1234_5678, 24'h5, 32'h7, 1,
            outcome(ST_ABORTED, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_FLUSH, 0, 0, 0, 1, outcome(ST_OK, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_START, 0, 0, 0, 1, outcome(ST_OK, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_GET, 0, 0, 0, 1, outcome(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_PUT, '1, '1, '1, 1,
            outcome(ST_OK, 0, 0, 0, 0, 1, 40'hFF_FFFF, 48'hFFFF_FFFF));
    add_row(ACT_PUT, 0, 0, 0, 1,
            outcome(ST_OK, 0, 0, 0, 0, 2, 40'hFF_FFFF, 48'hFFFF_FFFF));
    add_row(ACT_GET, 0, 0, 0, 1, outcome(ST_OK, '1, '1, '1, 16'd2, 1, 0, 0));
    add_row(ACT_ABORT, 0, 0, 0, 1, outcome(ST_OK, 0, 0, 0, 0, 1, 0, 0));
    // get while aborted with an entry still queued
    add_row(ACT_GET, 0, 0, 0, 1, outcome(ST_ABORTED, 0, 0, 0, 0, 1, 0, 0));
    add_row(ACT_PUT, 32'hDEAD_BEEF, 24'h10, 32'h20, 1,
            outcome(ST_ABORTED, 0, 0, 0, 0, 1, 0, 0));
    add_row(ACT_START, 0, 0, 0, 0, '0);
    add_row(ACT_PUT, 32'hA5A5_A5A5, 24'h80_0000, 32'h8000_0000, 0, '0);
    add_row(ACT_RSVD_A, '1, '1, '1, 0, '0);
    add_row(ACT_RSVD_B, 0, 0, 0, 0, '0);
    add_row(ACT_RSVD_C, 0, 0, 0, 0, '0);
    add_row(ACT_GET, 0, 0, 0, 0, '0);
    add_row(ACT_PUT, 32'h5A5A_5A5A, 24'h7F_FFFF, 32'h7FFF_FFFF, 0, '0);
    // flush with entries queued, then empty again
    add_row(ACT_FLUSH, 0, 0, 0, 1, outcome(ST_OK, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_GET, 0, 0, 0, 1, outcome(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_row(ACT_PUT, 1, 1, 1, 0, '0);
    add_row(ACT_GET, 0, 0, 0, 0, '0);

    ovh_plan = '{8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00};
    ovh_plan[4] = OVH_W'($urandom);

    // Reset once
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, overhead changed in between (entries may still be queued)
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_overhead(ovh_plan[p]);
      steady = (p == 2);
      seg_left = 0;
      put_bias = 50;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(120, 40);
          case ($urandom_range(2))
            0: put_bias = 95;
            1: put_bias = 50;
            default: put_bias = 10;
          endcase
        end
        seg_left--;
        w = pick_word(put_bias);
        send_word(w, 1'b0, '0);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[serial_packet_fifo] OK");
    end else begin
      $display("[serial_packet_fifo] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("[serial_packet_fifo] ERROR");
    $finish;
  end

endmodule
